// ===== design/dpd_pkg.sv =====
`timescale 1ns / 1ps
package dpd_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_MAX_REP   = 2'd3
  } cfg_reg_t;

  localparam int unsigned MIN_NEIGHBOURS = 4;
  localparam int unsigned FIELD_BITS     = 16;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pixel;
  } in_t;

  typedef struct packed {
    logic [10:0] bad_x;
    logic [15:0] bad_y;
    logic [15:0] bad_ordinal;
    logic        limit_reached;
  } out_t;

endpackage

// ===== design/dead_pixel_detector_3x3.sv =====
`timescale 1ns / 1ps
// Channel   Ports                          Moves per transaction
// in        in_valid, in_stall, in_data    one command with its pixel
// out       out_valid, out_stall, out_data one bad pixel report
// cfg       cfg_we, cfg_index, cfg_data    one register write
//
// A transaction is accepted each cycle while in_stall is low; line store reads are
// registered; a report is loaded as the resolving transaction leaves stage one.
// A centre resolves one row plus one pixel after its own pixel arrives.
// Reset is synchronous and clears control state; the line stores are not cleared.
// in_stall rises only while a report waits in the output register under out_stall
// and another transaction is held in the input register behind it.
module dead_pixel_detector_3x3 #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dpd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dpd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import dpd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;

  logic [11:0] width_r;
  logic [15:0] height_r, thresh_r, maxrep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 16'd480;
      thresh_r <= 16'd64;
      maxrep_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:     width_r  <= cfg_data[11:0];
        REG_HEIGHT:    height_r <= cfg_data;
        REG_THRESHOLD: thresh_r <= cfg_data;
        REG_MAX_REP:   maxrep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
  end

  logic out_free, adv, fire, in_acc, pd_in;
  logic s1_valid_r, s1_valid_nxt;
  cmd_t s1_cmd_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [16:0] s1_row_r;
  logic fwd_r;
  logic [PIXEL_BITS-1:0] fwd_val_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = !s1_valid_r || out_free;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign pd_in    = (cmd_t'(in_data.command) == CMD_PIXEL) ||
                    (cmd_t'(in_data.command) == CMD_DRAIN);

  logic [CW-1:0] col_r, col_nxt, col_a;
  logic [16:0] row_r, row_nxt, row_a;
  logic wrap0, end_row;
  logic [PIXEL_BITS-1:0] pix_in;

  assign wrap0   = {1'b0, col_r} >= w_eff;
  assign col_a   = wrap0 ? '0 : col_r;
  assign row_a   = (wrap0 && row_r != 17'h1FFFF) ? row_r + 17'd1 : row_r;
  assign end_row = ({1'b0, col_a} + WW'(1)) >= w_eff;
  assign pix_in  = (cmd_t'(in_data.command) == CMD_PIXEL) ? PIXEL_BITS'(in_data.pixel) : '0;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (cmd_t'(in_data.command) == CMD_START) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (pd_in) begin
        if (end_row) begin
          col_nxt = '0;
          row_nxt = (row_a != 17'h1FFFF) ? row_a + 17'd1 : row_a;
        end else begin
          col_nxt = col_a + CW'(1);
          row_nxt = row_a;
        end
      end
    end
  end

  logic s1_pd;
  logic [PIXEL_BITS-1:0] up_rd, lo_rd, up_val;

  assign s1_pd = (s1_cmd_r == CMD_PIXEL) || (s1_cmd_r == CMD_DRAIN);

  dpd_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PIXEL_BITS)) u_lower (
    .clk   (clk),
    .we    (in_acc && pd_in),
    .waddr (col_a),
    .wdata (pix_in),
    .re    (in_acc && pd_in),
    .raddr (col_a),
    .rdata (lo_rd)
  );

  dpd_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PIXEL_BITS)) u_upper (
    .clk   (clk),
    .we    (fire && s1_pd),
    .waddr (s1_col_r),
    .wdata (lo_rd),
    .re    (in_acc && pd_in),
    .raddr (col_a),
    .rdata (up_rd)
  );

  assign up_val = fwd_r ? fwd_val_r : up_rd;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && cmd_t'(in_data.command) != CMD_NONE) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (in_acc) begin
        fwd_r <= fire && s1_pd && pd_in && (s1_col_r == col_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_data.command);
      s1_pix_r  <= pix_in;
      s1_col_r  <= col_a;
      s1_row_r  <= row_a;
      fwd_val_r <= lo_rd;
    end
  end

  logic [PIXEL_BITS-1:0] win_r [9];
  logic [PIXEL_BITS-1:0] wn [9];
  logic [PIXEL_BITS-1:0] nb [8];
  logic [7:0] nb_mask;
  logic [3:0] nb_count;
  logic [PIXEL_BITS-1:0] median, centre, diff;
  logic c0, l_ok, r_ok, u_ok, d_ok, centre_in, hit;
  logic [WW-1:0] cx;
  logic signed [17:0] cy;
  logic [15:0] count_r, count_inc;
  logic stopped_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wn[r*3+0] = win_r[r*3+1];
      wn[r*3+1] = win_r[r*3+2];
    end
    wn[2] = up_val;
    wn[5] = lo_rd;
    wn[8] = s1_pix_r;
  end

  assign c0 = (s1_col_r == '0);
  assign cx = c0 ? w_eff - WW'(1) : WW'(s1_col_r) - WW'(1);
  assign cy = c0 ? $signed({1'b0, s1_row_r}) - 18'sd2 : $signed({1'b0, s1_row_r}) - 18'sd1;

  assign centre_in = (cy >= 18'sd0) && (cy < $signed({2'b00, height_r}));
  assign l_ok = (cx != '0);
  assign r_ok = (cx + WW'(1)) < w_eff;
  assign u_ok = cy >= 18'sd1;
  assign d_ok = (cy + 18'sd1) < $signed({2'b00, height_r});

  assign nb[0] = wn[0];
  assign nb[1] = wn[1];
  assign nb[2] = wn[2];
  assign nb[3] = wn[3];
  assign nb[4] = wn[5];
  assign nb[5] = wn[6];
  assign nb[6] = wn[7];
  assign nb[7] = wn[8];
  assign nb_mask = {d_ok && r_ok, d_ok, d_ok && l_ok, r_ok,
                    l_ok, u_ok && r_ok, u_ok, u_ok && l_ok};

  dpd_median8 #(.PIXEL_BITS(PIXEL_BITS)) u_median (
    .vals   (nb),
    .mask   (nb_mask),
    .count  (nb_count),
    .median (median)
  );

  assign centre    = wn[4];
  assign diff      = (centre > median) ? centre - median : median - centre;
  assign count_inc = count_r + 16'd1;
  assign hit = centre_in && (32'(nb_count) >= MIN_NEIGHBOURS) &&
               (FIELD_BITS'(diff) > thresh_r) && !stopped_r && (count_r < maxrep_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (fire) begin
      if (s1_cmd_r == CMD_START) begin
        count_r   <= '0;
        stopped_r <= 1'b0;
      end else if (s1_pd && hit) begin
        count_r <= count_inc;
        if (count_inc >= maxrep_r) begin
          stopped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (fire) begin
      if (s1_cmd_r == CMD_START) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= '0;
        end
      end else if (s1_pd) begin
        win_r <= wn;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && s1_pd && hit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_pd && hit) begin
      out_data_r.bad_x         <= 11'(cx);
      out_data_r.bad_y         <= cy[15:0];
      out_data_r.bad_ordinal   <= count_inc;
      out_data_r.limit_reached <= count_inc >= maxrep_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/dpd_line_store.sv =====
`timescale 1ns / 1ps
module dpd_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_BITS-1:0]     wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_BITS-1:0]     rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== design/dpd_median8.sv =====
`timescale 1ns / 1ps
module dpd_median8 #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic [PIXEL_BITS-1:0] vals [8],
  input  logic [7:0]            mask,
  output logic [3:0]            count,
  output logic [PIXEL_BITS-1:0] median
);

  logic [2:0] rank [8];
  logic [2:0] sel;

  // Each valid value gets a unique rank among the valid values; ties go by position.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 8; j++) begin
        if (mask[j] && j != i &&
            ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)))) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
  end

  assign count = 4'($countones(mask));
  assign sel   = 3'(count >> 1);

  always_comb begin
    median = '0;
    for (int i = 0; i < 8; i++) begin
      if (mask[i] && rank[i] == sel) begin
        median = median | vals[i];
      end
    end
  end

endmodule

// ===== design/dpd_checker.sv =====
`timescale 1ns / 1ps
module dpd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input dpd_pkg::out_t out_data
);

  // A held report keeps its contents until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("report changed while stalled");

  // Input backpressure only comes from a blocked report.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked report");

  // A stalled input transaction stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input transaction withdrawn while stalled");

  a_ordinal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bad_ordinal != 16'd0)
    else $error("report with zero ordinal");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid after reset");

endmodule

bind dead_pixel_detector_3x3 dpd_checker u_dpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dpd_pkg::*;

  localparam int MAXW = 2048;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dead_pixel_detector_3x3 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the detector used to work out the expected reports.
  int unsigned img_w = 640, img_h = 480, thresh = 64, report_limit = 65535;
  logic [15:0] upper_line [MAXW];
  logic [15:0] lower_line [MAXW];
  logic [15:0] win [9];
  int unsigned col_pos, row_pos, reports_made;
  bit reports_off;

  in_t pending_items [$];
  out_t expected_reports [$];
  int errors = 0, items_sent = 0, reports_seen = 0, frames_run = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;

  function automatic void judge_centre(int cx, int cy, int ccol, int w, int h);
    int s [8];
    int n, v, j, centre, median, diff;
    out_t r;
    n = 0;
    if (cx < 0 || cy < 0 || cx >= w || cy >= h) return;
    centre = int'(win[3 + ccol]);
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (!(dx == 0 && dy == 0) && cx + dx >= 0 && cy + dy >= 0 && cx + dx < w &&
            cy + dy < h && ccol + dx >= 0 && ccol + dx <= 2) begin
          s[n] = int'(win[(1 + dy) * 3 + ccol + dx]);
          n++;
        end
      end
    end
    if (n < MIN_NEIGHBOURS) return;
    for (int i = 1; i < n; i++) begin
      v = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > v) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = v;
    end
    median = s[n / 2];
    diff = centre > median ? centre - median : median - centre;
    if (diff <= thresh || reports_off || reports_made >= report_limit) return;
    reports_made++;
    r.bad_x = cx[10:0];
    r.bad_y = cy[15:0];
    r.bad_ordinal = reports_made[15:0];
    r.limit_reached = 1'b0;
    if (reports_made >= report_limit) begin
      reports_off = 1'b1;
      r.limit_reached = 1'b1;
    end
    expected_reports.push_back(r);
  endfunction

  function automatic void next_row();
    col_pos = 0;
    if (row_pos < 131071) row_pos++;
  endfunction

  function automatic void predict_reports(in_t d);
    int w, c;
    logic [15:0] pix, up, lo;
    w = img_w == 0 ? 1 : (img_w > MAXW ? MAXW : img_w);
    pix = d.pixel;
    if (d.command == CMD_NONE) return;
    if (d.command == CMD_START) begin
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      reports_made = 0;
      reports_off = 1'b0;
      return;
    end
    if (d.command == CMD_DRAIN) pix = '0;
    if (col_pos >= w) next_row();
    c = col_pos;
    if (c == 0) judge_centre(w - 1, int'(row_pos) - 2, 2, w, img_h);
    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c] = lo;
    lower_line[c] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = pix;
    if (c >= 1) judge_centre(c - 1, int'(row_pos) - 1, 1, w, img_h);
    if (c + 1 >= w) next_row();
    else col_pos = c + 1;
  endfunction

  // Driver.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reports(pending_items.pop_front());
        items_sent++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  int out_gap = 0, hold_cnt = 0;
  bit hold_done = 1'b0;
  out_t exp_r;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("unexpected report x=%0d y=%0d", out_data.bad_x, out_data.bad_y);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (out_data.bad_x !== exp_r.bad_x) begin
          $error("bad_x expected %0d actual %0d", exp_r.bad_x, out_data.bad_x);
          errors++;
        end
        if (out_data.bad_y !== exp_r.bad_y) begin
          $error("bad_y expected %0d actual %0d", exp_r.bad_y, out_data.bad_y);
          errors++;
        end
        if (out_data.bad_ordinal !== exp_r.bad_ordinal) begin
          $error("bad_ordinal expected %0d actual %0d", exp_r.bad_ordinal,
                 out_data.bad_ordinal);
          errors++;
        end
        if (out_data.limit_reached !== exp_r.limit_reached) begin
          $error("limit_reached expected %0d actual %0d", exp_r.limit_reached,
                 out_data.limit_reached);
          errors++;
        end
      end
    end
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dead_pixel_detector_3x3 test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WIDTH: img_w = 32'(val[11:0]);
      REG_HEIGHT: img_h = 32'(val);
      REG_THRESHOLD: thresh = 32'(val);
      default: report_limit = 32'(val);
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_reports.size() > 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic in_t make_item(cmd_t c, logic [15:0] p);
    in_t t;
    t.command = c;
    t.pixel = p;
    return t;
  endfunction

  // One frame: start, raster pixels around a smooth level with spikes, then drains.
  task automatic run_frame(int w, int h, int thr, int lim, bit fixed_pix, logic [15:0] fv);
    int we, base, p;
    wait_idle();
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_THRESHOLD, 16'(thr));
    write_reg(REG_MAX_REP, 16'(lim));
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_run++;
    we = w == 0 ? 1 : (w > MAXW ? MAXW : w);
    base = $urandom_range(0, 65535);
    pending_items.push_back(make_item(CMD_START, 16'($urandom)));
    for (int i = 0; i < we * (h == 0 ? 1 : h); i++) begin
      if ($urandom_range(0, 19) == 0)
        pending_items.push_back(make_item(CMD_NONE, 16'($urandom)));
      if (fixed_pix) p = int'(fv);
      else if ($urandom_range(0, 5) == 0) p = $urandom_range(0, 65535);
      else p = (base + $urandom_range(0, 40)) & 16'hffff;
      if (!fixed_pix && $urandom_range(0, 60) == 0)
        pending_items.push_back(make_item(CMD_DRAIN, 16'($urandom)));
      else
        pending_items.push_back(make_item(CMD_PIXEL, 16'(p)));
    end
    for (int i = 0; i < we + 1; i++)
      pending_items.push_back(make_item(CMD_DRAIN, 16'($urandom)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6))
        pending_items.push_back(make_item(CMD_PIXEL, 16'($urandom)));
  endtask

  int thr_r, lim_r;
  initial begin
    foreach (win[i]) win[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Directed frames: degenerate geometry, extreme thresholds and limits.
    run_frame(0, 3, 0, 65535, 1'b0, 0);
    run_frame(1, 5, 0, 65535, 1'b0, 0);
    run_frame(5, 1, 0, 65535, 1'b0, 0);
    run_frame(4, 0, 0, 65535, 1'b0, 0);
    run_frame(3, 3, 0, 0, 1'b0, 0);
    run_frame(4, 4, 65535, 65535, 1'b0, 0);
    run_frame(3, 3, 0, 1, 1'b1, 16'hffff);
    run_frame(4, 3, 0, 2, 1'b1, 16'h0000);
    run_frame(6, 5, 100, 1, 1'b0, 0);
    wait_idle();
    hold_go = 1'b1;
    run_frame(10, 10, 0, 65535, 1'b0, 0);
    while (items_sent < 470) begin
      case ($urandom_range(0, 2))
        0: thr_r = 0;
        1: thr_r = $urandom_range(20, 3000);
        default: thr_r = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 4))
        0: lim_r = $urandom_range(0, 3);
        1: lim_r = $urandom_range(0, 65535);
        default: lim_r = 65535;
      endcase
      if (items_sent > 400) quiet = 1'b1;
      run_frame($urandom_range(2, 12), $urandom_range(2, 10), thr_r, lim_r, 1'b0, 0);
    end
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d frames, %0d input transactions, %0d bad pixel reports checked.",
             frames_run, items_sent, reports_seen);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("dead_pixel_detector_3x3 test passed");
    end else begin
      $display("dead_pixel_detector_3x3 test failed");
    end
    $finish;
  end
endmodule
